// ===== rtl/core/rlfse_pkg.sv =====
// ----------------------------------------------------------------------------
// rlfse_pkg
// Shared types and constants of the RGB LED frame SPI encoder core.
// ----------------------------------------------------------------------------
package rlfse_pkg;

	localparam int NUM_LEDS     = 32;
	localparam int PREFIX_BYTES = 40;

	localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int PRE_W = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
	localparam bit HAS_PREFIX = (PREFIX_BYTES != 0);

	localparam logic [7:0] ZERO_CODE_RST = 8'h70;
	localparam logic [7:0] ONE_CODE_RST  = 8'h7c;

	localparam logic [1:0] ACT_SET_ONE = 2'd0;
	localparam logic [1:0] ACT_SET_ALL = 2'd1;
	localparam logic [1:0] ACT_FETCH   = 2'd2;

	localparam logic [1:0] REG_ORDER_GREEN_FIRST = 2'd0;
	localparam logic [1:0] REG_ZERO_CODE         = 2'd1;
	localparam logic [1:0] REG_ONE_CODE          = 2'd2;

	localparam logic [1:0] SLOT_FIRST  = 2'd0;
	localparam logic [1:0] SLOT_SECOND = 2'd1;
	localparam logic [1:0] SLOT_BLUE   = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_word_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       last_of_frame;
	} out_word_t;

	typedef struct packed {
		logic set_one;
		logic set_all;
		logic fetch;
	} ctrl_cmd_t;

endpackage

// ===== rtl/core/rgb_led_frame_spi_encoder_core.sv =====
// ----------------------------------------------------------------------------
// rgb_led_frame_spi_encoder_core
// A fetched byte appears on result in the cycle after its word is taken.
// Throughput: one word per cycle; busy never rises, since the pixel read and
// code select feeding the output register are combinational.
// Reset: pixels clear to zero, frame restarts at its first prefix byte,
// registers return to their defaults. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module rgb_led_frame_spi_encoder_core import rlfse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_word_t   item,
	output logic       result_valid,
	output out_word_t  result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	ctrl_cmd_t cmd;

	rlfse_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (item.action),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid)
	);

	rlfse_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

// ===== rtl/core/rlfse_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlfse_ctrl
// Decodes accepted words into datapath commands and times the result strobe.
// ----------------------------------------------------------------------------
module rlfse_ctrl import rlfse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	output logic       busy,
	output ctrl_cmd_t  cmd,
	output logic       result_valid
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_comb begin
		cmd.set_one = accept && (action == ACT_SET_ONE);
		cmd.set_all = accept && (action == ACT_SET_ALL);
		cmd.fetch   = accept && (action == ACT_FETCH);
	end

	always_comb begin
		case (state_q)
			ST_IDLE: state_d = cmd.fetch ? ST_EMIT : ST_IDLE;
			ST_EMIT: state_d = cmd.fetch ? ST_EMIT : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign result_valid = (state_q == ST_EMIT);

endmodule

// ===== rtl/core/rlfse_dp.sv =====
// ----------------------------------------------------------------------------
// rlfse_dp
// Pixel store, configuration registers, frame position counters and the
// bit-to-code encoder with its output register.
// ----------------------------------------------------------------------------
module rlfse_dp import rlfse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	input  in_word_t   item,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output out_word_t  result
);

	logic [23:0]      pixel_q [NUM_LEDS];
	logic             green_first_q;
	logic [7:0]       zero_code_q;
	logic [7:0]       one_code_q;

	logic             in_prefix_q;
	logic [PRE_W-1:0] pre_cnt_q;
	logic [LED_W-1:0] led_q;
	logic [1:0]       slot_q;
	logic [2:0]       bit_q;

	out_word_t        result_q;
	logic [23:0]      pix;
	logic [7:0]       colour;
	logic             bit_val;
	logic             last;
	logic [23:0]      wr_val;

	assign wr_val = {item.red, item.green, item.blue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				pixel_q[i] <= '0;
			end
		end else if (cmd.set_all) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				pixel_q[i] <= wr_val;
			end
		end else if (cmd.set_one && ({1'b0, item.led_index} < 9'(NUM_LEDS))) begin
			pixel_q[item.led_index[LED_W-1:0]] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_first_q <= 1'b0;
			zero_code_q   <= ZERO_CODE_RST;
			one_code_q    <= ONE_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORDER_GREEN_FIRST: green_first_q <= cfg_data[0];
				REG_ZERO_CODE:         zero_code_q   <= cfg_data;
				REG_ONE_CODE:          one_code_q    <= cfg_data;
				default:               ;
			endcase
		end
	end

	// select the colour byte in send order, most significant bit first
	always_comb begin
		pix = pixel_q[led_q];
		case (slot_q)
			SLOT_FIRST:  colour = green_first_q ? pix[15:8] : pix[23:16];
			SLOT_SECOND: colour = green_first_q ? pix[23:16] : pix[15:8];
			SLOT_BLUE:   colour = pix[7:0];
			default:     colour = pix[7:0];
		endcase
		bit_val = colour[~bit_q];
		last    = ~in_prefix_q && (led_q == LED_W'(NUM_LEDS - 1))
			&& (slot_q == SLOT_BLUE) && (bit_q == 3'd7);
	end

	// advance the frame position on each fetch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_prefix_q <= HAS_PREFIX;
			pre_cnt_q   <= '0;
			led_q       <= '0;
			slot_q      <= SLOT_FIRST;
			bit_q       <= '0;
		end else if (cmd.fetch) begin
			if (in_prefix_q) begin
				if (pre_cnt_q == PRE_W'(PREFIX_BYTES - 1)) begin
					in_prefix_q <= 1'b0;
					pre_cnt_q   <= '0;
				end else begin
					pre_cnt_q <= pre_cnt_q + 1'b1;
				end
			end else if (last) begin
				in_prefix_q <= HAS_PREFIX;
				led_q       <= '0;
				slot_q      <= SLOT_FIRST;
				bit_q       <= '0;
			end else if (bit_q == 3'd7) begin
				bit_q <= '0;
				if (slot_q == SLOT_BLUE) begin
					slot_q <= SLOT_FIRST;
					led_q  <= led_q + 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end else begin
				bit_q <= bit_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			result_q.spi_byte      <= in_prefix_q ? 8'h00 :
				(bit_val ? one_code_q : zero_code_q);
			result_q.last_of_frame <= last;
		end
	end

	assign result = result_q;

endmodule

// ===== bench/rgb_led_frame_spi_encoder_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_led_frame_spi_encoder_core_test
// Drives pixel writes and frame fetches into the encoder and compares every
// fetched SPI byte and its end-of-frame flag with an in-bench model of the
// pixel store, frame position and code registers, under several settings.
// ----------------------------------------------------------------------------
module rgb_led_frame_spi_encoder_core_test;
	import rlfse_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int FRAME_LEN   = PREFIX_BYTES + NUM_LEDS * 24;
	localparam int PHASE_WORDS = 225;
	localparam int STALL_LIMIT = 500;

	typedef struct packed {
		in_word_t  w;
		logic      typed;
		out_word_t want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	in_word_t   item = '0;
	logic       result_valid;
	out_word_t  result;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_ORDER_GREEN_FIRST;
	logic [7:0] cfg_data = 8'h00;

	logic [23:0] rgb_store [NUM_LEDS];
	int unsigned frame_pos = 0;
	logic        green_first = 1'b0;
	logic [7:0]  zero_byte = ZERO_CODE_RST;
	logic [7:0]  one_byte = ONE_CODE_RST;

	out_word_t  pending_bytes [$];
	dir_row_t   directed [$];
	out_word_t  want_word;
	int         errors = 0;
	int         stall_cycles = 0;
	bit         gaps_on = 1'b1;

	rgb_led_frame_spi_encoder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic dir_row_t row(logic [1:0] a, logic [7:0] i, logic [7:0] r,
			logic [7:0] g, logic [7:0] b, logic typed);
		dir_row_t d;
		d.w.action    = a;
		d.w.led_index = i;
		d.w.red       = r;
		d.w.green     = g;
		d.w.blue      = b;
		d.typed       = typed;
		d.want        = '0;
		return d;
	endfunction

	function automatic logic [7:0] encode_byte(int unsigned pos);
		int unsigned d;
		int unsigned led;
		int unsigned led_off;
		int unsigned slot;
		int unsigned bit_idx;
		logic [7:0]  colour;
		if (pos < PREFIX_BYTES)
			return 8'h00;
		d       = pos - PREFIX_BYTES;
		led     = d / 24;
		led_off = d % 24;
		slot    = led_off / 8;
		bit_idx = 7 - (led_off % 8);
		if (slot == SLOT_BLUE)
			colour = rgb_store[led][7:0];
		else if ((slot == SLOT_FIRST) == green_first)
			colour = rgb_store[led][15:8];
		else
			colour = rgb_store[led][23:16];
		return colour[bit_idx] ? one_byte : zero_byte;
	endfunction

	// advance the model by one word; returns 1 when a byte is fetched
	function automatic bit model_word(in_word_t w, output out_word_t got);
		got = '0;
		case (w.action)
			ACT_SET_ONE: begin
				if (w.led_index < NUM_LEDS)
					rgb_store[w.led_index] = {w.red, w.green, w.blue};
				return 1'b0;
			end
			ACT_SET_ALL: begin
				foreach (rgb_store[k])
					rgb_store[k] = {w.red, w.green, w.blue};
				return 1'b0;
			end
			ACT_FETCH: begin
				if (frame_pos >= FRAME_LEN)
					frame_pos = 0;
				got.spi_byte      = encode_byte(frame_pos);
				got.last_of_frame = (frame_pos + 1 == FRAME_LEN);
				frame_pos         = got.last_of_frame ? 0 : frame_pos + 1;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] pick_level();
		int unsigned k;
		k = $urandom_range(0, 7);
		if (k == 0)
			return 8'h00;
		if (k == 1)
			return 8'hff;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic in_word_t random_word();
		in_word_t    w;
		int unsigned k;
		k           = $urandom_range(0, 99);
		w.led_index = 8'($urandom_range(0, 255));
		w.red       = pick_level();
		w.green     = pick_level();
		w.blue      = pick_level();
		if (k < 80) begin
			w.action = ACT_FETCH;
		end else if (k < 93) begin
			w.action = ACT_SET_ONE;
			if ($urandom_range(0, 3) != 0)
				w.led_index = 8'($urandom_range(0, NUM_LEDS - 1));
			else
				w.led_index = 8'($urandom_range(NUM_LEDS, 255));
		end else if (k < 96) begin
			w.action = ACT_SET_ALL;
		end else begin
			w.action = ACT_UNUSED;
		end
		return w;
	endfunction

	task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
		out_word_t got;
		start <= 1'b1;
		item  <= w;
		do @(posedge clk); while (busy);
		if (model_word(w, got))
			pending_bytes.push_back(typed ? want : got);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_codes(input logic grn, input logic [7:0] zc, input logic [7:0] oc,
			input bit poke_unused);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ORDER_GREEN_FIRST;
		cfg_data  <= {7'($urandom_range(0, 127)), grn};
		@(posedge clk);
		cfg_index <= REG_ZERO_CODE;
		cfg_data  <= zc;
		@(posedge clk);
		cfg_index <= REG_ONE_CODE;
		cfg_data  <= oc;
		@(posedge clk);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data  <= 8'($urandom_range(0, 255));
			@(posedge clk);
		end
		cfg_we      <= 1'b0;
		green_first = grn;
		zero_byte   = zc;
		one_byte    = oc;
	endtask

	task automatic random_phase();
		in_word_t w;
		int       n;
		n = 0;
		while (n < PHASE_WORDS) begin
			w = random_word();
			send_word(w, 1'b0, '0);
			if (w.action != ACT_UNUSED)
				n++;
		end
		drain();
	endtask

	task automatic flag_error(input string what, input out_word_t want, input out_word_t got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: expected byte %02h last %0d, got byte %02h last %0d",
				$realtime, what, want.spi_byte, want.last_of_frame,
				got.spi_byte, got.last_of_frame);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) begin
				if (pending_bytes.size() == 0) begin
					flag_error("unexpected byte", '0, result);
				end else begin
					want_word = pending_bytes.pop_front();
					if (result.spi_byte !== want_word.spi_byte ||
							result.last_of_frame !== want_word.last_of_frame)
						flag_error("mismatch", want_word, result);
				end
			end
			if ((start && !busy) || result_valid || cfg_we)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		foreach (rgb_store[k])
			rgb_store[k] = '0;

		directed.push_back(row(ACT_FETCH,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		directed.push_back(row(ACT_SET_ONE, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0));
		directed.push_back(row(ACT_SET_ONE, 8'h1f, 8'hff, 8'h00, 8'hff, 1'b0));
		directed.push_back(row(ACT_SET_ONE, 8'h20, 8'hff, 8'hff, 8'hff, 1'b0));
		directed.push_back(row(ACT_SET_ONE, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0));
		directed.push_back(row(ACT_UNUSED,  8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
		directed.push_back(row(ACT_FETCH,   8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
		directed.push_back(row(ACT_SET_ALL, 8'haa, 8'h81, 8'h42, 8'h24, 1'b0));
		directed.push_back(row(ACT_FETCH,   8'h55, 8'h00, 8'h00, 8'h00, 1'b1));
		directed.push_back(row(ACT_SET_ONE, 8'h01, 8'h80, 8'h01, 8'hfe, 1'b0));
		directed.push_back(row(ACT_SET_ONE, 8'h02, 8'h01, 8'h80, 8'h7f, 1'b0));
		directed.push_back(row(ACT_SET_ONE, 8'h1e, 8'h5a, 8'ha5, 8'h3c, 1'b0));
		directed.push_back(row(ACT_FETCH,   8'h00, 8'hff, 8'h00, 8'hff, 1'b1));
		directed.push_back(row(ACT_FETCH,   8'hff, 8'h00, 8'hff, 8'h00, 1'b1));
		directed.push_back(row(ACT_UNUSED,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		directed.push_back(row(ACT_SET_ONE, 8'h1f, 8'h80, 8'h7f, 8'h01, 1'b0));
		directed.push_back(row(ACT_SET_ONE, 8'h21, 8'h00, 8'h00, 8'h00, 1'b0));
		directed.push_back(row(ACT_FETCH,   8'h80, 8'h80, 8'h80, 8'h80, 1'b1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[k])
			send_word(directed[k].w, directed[k].typed, directed[k].want);
		drain();

		random_phase();
		program_codes(1'b1, 8'h00, 8'hff, 1'b0);
		random_phase();
		gaps_on = 1'b0;
		program_codes(1'b0, 8'hff, 8'h00, 1'b1);
		random_phase();
		gaps_on = 1'b1;
		program_codes(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'b1);
		random_phase();
		program_codes(1'b1, ZERO_CODE_RST, ONE_CODE_RST, 1'b0);
		random_phase();
		gaps_on = 1'b0;
		program_codes(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'b0);
		random_phase();

		repeat (4) @(posedge clk);
		if (errors == 0 && pending_bytes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
